FILE: src/ipd_pkg.sv
package ipd_pkg;

    localparam int unsigned LimitWidth = 10;
    localparam int unsigned LenWidth   = 16;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned HdrLen     = 5;
    localparam int unsigned HdrIdxW    = 3;

    localparam logic [LimitWidth-1:0] LIMIT_RESET    = 10'd256;
    localparam logic [LimitWidth-1:0] HEADER_END_POS = 10'd7;
    localparam logic [LenWidth-1:0]   LEN_MAX        = 16'hFFFF;

    localparam logic [ByteWidth-1:0] CHR_PLUS  = 8'h2b;
    localparam logic [ByteWidth-1:0] CHR_I     = 8'h49;
    localparam logic [ByteWidth-1:0] CHR_P     = 8'h50;
    localparam logic [ByteWidth-1:0] CHR_D     = 8'h44;
    localparam logic [ByteWidth-1:0] CHR_COMMA = 8'h2c;
    localparam logic [ByteWidth-1:0] CHR_COLON = 8'h3a;
    localparam logic [ByteWidth-1:0] CHR_ZERO  = 8'h30;
    localparam logic [ByteWidth-1:0] CHR_NINE  = 8'h39;

    localparam logic [HdrIdxW-1:0] HDR_LAST = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_FIRST   = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [HdrIdxW-1:0]    hdr_match;
        logic [LimitWidth-1:0] position;
        logic [LenWidth-1:0]   decl_len;
        logic [LenWidth-1:0]   bytes_left;
    } t_state;

    typedef struct packed {
        logic                 data_valid;
        logic [ByteWidth-1:0] data_byte;
        logic                 frame_done;
        logic [LenWidth-1:0]  payload_len;
        logic                 frame_abort;
    } t_result;

    // expected header character at a given match index
    function automatic logic [ByteWidth-1:0] hdr_byte(input logic [HdrIdxW-1:0] idx);
        logic [ByteWidth-1:0] chr;
        unique case (idx)
            3'd0:    chr = CHR_PLUS;
            3'd1:    chr = CHR_I;
            3'd2:    chr = CHR_P;
            3'd3:    chr = CHR_D;
            3'd4:    chr = CHR_COMMA;
            default: chr = '0;
        endcase
        return chr;
    endfunction

    // accumulate one decimal digit, saturate; non-digits leave the length alone
    function automatic logic [LenWidth-1:0] add_digit(input logic [LenWidth-1:0] len,
                                                     input logic [ByteWidth-1:0] chr);
        logic [LenWidth+3:0] wide;
        logic [LenWidth+3:0] sum;
        logic [LenWidth-1:0] res;
        wide = {4'b0, len};
        sum  = (wide << 3) + (wide << 1) + {{(LenWidth){1'b0}}, chr[3:0]};
        res  = len;
        if (chr >= CHR_ZERO && chr <= CHR_NINE) begin
            res = (sum > {4'b0, LEN_MAX}) ? LEN_MAX : sum[LenWidth-1:0];
        end
        return res;
    endfunction

endpackage

FILE: src/ipd_step.sv
module ipd_step import ipd_pkg::*; (
    input  t_state                i_state,
    input  logic [ByteWidth-1:0]  i_byte,
    input  logic [LimitWidth-1:0] i_limit,
    output t_state                o_state,
    output t_result               o_result
);

    logic [LimitWidth:0]  pos_inc;
    logic [LenWidth-1:0]  left_dec;

    assign pos_inc  = {1'b0, i_state.position} + {{LimitWidth{1'b0}}, 1'b1};
    assign left_dec = (i_state.bytes_left != '0) ? i_state.bytes_left - 1'b1
                                                  : i_state.bytes_left;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.phase == PH_HUNT) begin
            if (i_state.hdr_match <= HDR_LAST && i_byte == hdr_byte(i_state.hdr_match)) begin
                if (i_state.hdr_match == HDR_LAST) begin
                    o_state.hdr_match  = '0;
                    o_state.phase      = PH_FIRST;
                    o_state.position   = HEADER_END_POS;
                    o_state.decl_len   = '0;
                    o_state.bytes_left = '0;
                end else begin
                    o_state.hdr_match = i_state.hdr_match + 1'b1;
                end
            end else begin
                o_state.hdr_match = '0;
            end
        end else if (pos_inc > {1'b0, i_limit}) begin
            // frame ran past the limit: drop it and hunt again
            o_result.frame_abort = 1'b1;
            o_state.phase        = PH_HUNT;
            o_state.hdr_match    = '0;
            o_state.position     = '0;
        end else begin
            o_state.position = pos_inc[LimitWidth-1:0];
            unique case (i_state.phase)
                PH_FIRST: begin
                    o_state.decl_len = add_digit(i_state.decl_len, i_byte);
                    o_state.phase    = PH_DIGITS;
                end
                PH_DIGITS: begin
                    if (i_byte == CHR_COLON) begin
                        o_state.bytes_left = i_state.decl_len;
                        o_state.phase      = PH_PAYLOAD;
                    end else begin
                        o_state.decl_len = add_digit(i_state.decl_len, i_byte);
                    end
                end
                default: begin
                    o_state.bytes_left = left_dec;
                    if (i_state.bytes_left != '0) begin
                        o_result.data_valid = 1'b1;
                        o_result.data_byte  = i_byte;
                    end
                    if (left_dec == '0) begin
                        o_result.frame_done  = 1'b1;
                        o_result.payload_len = i_state.decl_len;
                        o_state.phase        = PH_HUNT;
                        o_state.hdr_match    = '0;
                    end
                end
            endcase
        end
    end

endmodule

FILE: src/ipd_frame_parser.sv
// ipd_frame_parser: pulls "+IPD,<len>:<payload>" frames out of a byte stream.
// The accepted byte is registered in r_in_*, and its result in r_out_*.
// Throughput: one byte per cycle; the input register, the state update and the
// result register advance whenever the result slot is empty or being taken.
// Reset (synchronous, active low): pipeline empties, parser hunts for a header,
// frame_limit returns to 256.
module ipd_frame_parser import ipd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ByteWidth-1:0]  i_rx_byte,
    // result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_data_valid,
    output logic [ByteWidth-1:0]  o_data_byte,
    output logic                  o_frame_done,
    output logic [LenWidth-1:0]   o_payload_len,
    output logic                  o_frame_abort,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Pipeline: r_in_* holds the accepted byte, r_state is the parser state,
    // r_out_* holds the finished result until the consumer takes it.
    logic                  r_in_valid;
    logic [ByteWidth-1:0]  r_in_byte;
    t_state                r_state;
    logic                  r_out_valid;
    t_result               r_out;
    logic [LimitWidth-1:0] r_frame_limit;

    t_state                n_state;
    t_result               n_out;
    logic                  advance;
    logic                  cfg_write;

    // advance the compute stage when a byte is waiting and the result slot is free or being taken
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    ipd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_limit  (r_frame_limit),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_HUNT, default: '0};
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                // drop the delivered result
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Configuration: frame_limit answers at byte addresses 0 to 3; 4 to 7 are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= LIMIT_RESET;
        end else if (cfg_write) begin
            r_frame_limit <= pwdata[LimitWidth-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-LimitWidth){1'b0}}, r_frame_limit};

    assign o_valid        = r_out_valid;
    assign o_data_valid   = r_out.data_valid;
    assign o_data_byte    = r_out.data_byte;
    assign o_frame_done   = r_out.frame_done;
    assign o_payload_len  = r_out.payload_len;
    assign o_frame_abort  = r_out.frame_abort;

`ifndef SYNTHESIS
    a_header_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hdr_match <= HDR_LAST)
        else $error("header match index out of range");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed byte produced no result");

    a_abort_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_abort) |->
            (!r_out.data_valid && !r_out.frame_done && r_out.payload_len == '0))
        else $error("abort result carries frame data");

    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out.frame_done) |=> (r_state.phase == PH_HUNT))
        else $error("frame end did not restart header hunt");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb import ipd_pkg::*; ();

    // Register map: frame_limit is the only register, at byte address 0.
    localparam logic [2:0] ADDR_FRAME_LIMIT = 3'd0;

    // Cycles without any transaction on any port before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    // Idle cycles before a register write, a little more than the two-stage pipeline.
    localparam int PIPE_SETTLE = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [ByteWidth-1:0] i_rx_byte = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_data_valid;
    logic [ByteWidth-1:0] o_data_byte;
    logic                 o_frame_done;
    logic [LenWidth-1:0]  o_payload_len;
    logic                 o_frame_abort;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    ipd_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_data_valid   (o_data_valid),
        .o_data_byte    (o_data_byte),
        .o_frame_done   (o_frame_done),
        .o_payload_len  (o_payload_len),
        .o_frame_abort  (o_frame_abort),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Tracks the parser state byte by byte and holds the results each byte must produce,
    // oldest first.
    class ipd_parse_tracker;
        logic [LimitWidth-1:0] lim;
        t_phase                ph;
        logic [HdrIdxW-1:0]    hmatch;
        logic [LimitWidth-1:0] fpos;
        logic [LenWidth-1:0]   dlen;
        logic [LenWidth-1:0]   left;
        logic [ByteWidth-1:0]  hdr_seq [HdrLen];
        t_result               pending_results [$];
        int                    errors;

        function new();
            lim     = LIMIT_RESET;
            ph      = PH_HUNT;
            hmatch  = '0;
            fpos    = '0;
            dlen    = '0;
            left    = '0;
            hdr_seq = '{CHR_PLUS, CHR_I, CHR_P, CHR_D, CHR_COMMA};
            errors  = 0;
        endfunction

        // Decimal accumulate with saturation; anything but a digit leaves the length alone.
        function logic [LenWidth-1:0] push_digit(logic [LenWidth-1:0] len,
                                                 logic [ByteWidth-1:0] c);
            int v;
            if (c < CHR_ZERO || c > CHR_NINE) begin
                return len;
            end
            v = int'(len) * 10 + int'(c) - int'(CHR_ZERO);
            return (v > int'(LEN_MAX)) ? LEN_MAX : LenWidth'(v);
        endfunction

        function void take_byte(logic [ByteWidth-1:0] b);
            t_result          r;
            logic [LimitWidth:0] nxt;
            r = '0;
            if (ph == PH_HUNT) begin
                // A mismatching byte drops the match and is not retried as a '+'.
                if (hmatch < HdrLen && b == hdr_seq[hmatch]) begin
                    if (hmatch == HDR_LAST) begin
                        ph     = PH_FIRST;
                        hmatch = '0;
                        fpos   = HEADER_END_POS;
                        dlen   = '0;
                        left   = '0;
                    end else begin
                        hmatch = hmatch + 1'b1;
                    end
                end else begin
                    hmatch = '0;
                end
            end else begin
                // The limit check comes first in every phase after the header.
                nxt = {1'b0, fpos} + 1'b1;
                if (nxt > {1'b0, lim}) begin
                    r.frame_abort = 1'b1;
                    ph     = PH_HUNT;
                    hmatch = '0;
                    fpos   = '0;
                end else begin
                    fpos = nxt[LimitWidth-1:0];
                    case (ph)
                        PH_FIRST: begin
                            // never a terminator, even when it is ':'
                            dlen = push_digit(dlen, b);
                            ph   = PH_DIGITS;
                        end
                        PH_DIGITS: begin
                            if (b == CHR_COLON) begin
                                left = dlen;
                                ph   = PH_PAYLOAD;
                            end else begin
                                dlen = push_digit(dlen, b);
                            end
                        end
                        default: begin
                            if (left != 0) begin
                                left         = left - 1'b1;
                                r.data_valid = 1'b1;
                                r.data_byte  = b;
                            end
                            // with a zero length this byte closes the frame and is dropped
                            if (left == 0) begin
                                r.frame_done  = 1'b1;
                                r.payload_len = dlen;
                                ph            = PH_HUNT;
                                hmatch        = '0;
                            end
                        end
                    endcase
                end
            end
            pending_results.push_back(r);
        endfunction

        function void cmp_field(string name, logic [LenWidth-1:0] want, logic [LenWidth-1:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: dv=%0d byte=%0h done=%0d len=%0d abort=%0d",
                         $time, got.data_valid, got.data_byte, got.frame_done,
                         got.payload_len, got.frame_abort);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            cmp_field("data_valid",  LenWidth'(want.data_valid),  LenWidth'(got.data_valid));
            cmp_field("data_byte",   LenWidth'(want.data_byte),   LenWidth'(got.data_byte));
            cmp_field("frame_done",  LenWidth'(want.frame_done),  LenWidth'(got.frame_done));
            cmp_field("payload_len", want.payload_len,            got.payload_len);
            cmp_field("frame_abort", LenWidth'(want.frame_abort), LenWidth'(got.frame_abort));
        endfunction
    endclass

    ipd_parse_tracker     parser_ref;
    logic [ByteWidth-1:0] traffic [$];
    bit                   in_burst;
    bit                   out_burst;
    int                   rx_hold_req;

    // Gap before the next byte; flip between gappy and back-to-back now and then.
    function automatic int in_gap();
        if ($urandom_range(0, 99) == 0) begin
            in_burst = !in_burst;
        end
        return in_burst ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic int out_gap();
        if ($urandom_range(0, 99) == 0) begin
            out_burst = !out_burst;
        end
        return out_burst ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void push_str(string s);
        for (int k = 0; k < s.len(); k++) begin
            traffic.push_back(s[k]);
        end
    endfunction

    // Append one well-formed frame with random payload; the length text may carry a
    // leading ':' (taken as a length character), a leading zero, or stray non-digits.
    function automatic void add_frame(int lim);
        int                   len;
        string                digs;
        logic [ByteWidth-1:0] junk;
        push_str("+IPD,");
        if (lim <= 300 && $urandom_range(0, 15) == 0) begin
            // land right around the limit: some fit, some abort
            len = $urandom_range(lim - 12, lim - 6);
        end else begin
            len = $urandom_range(0, 12);
        end
        if ($urandom_range(0, 7) == 0) begin
            traffic.push_back(CHR_COLON);
        end
        if ($urandom_range(0, 3) == 0) begin
            traffic.push_back(CHR_ZERO);
        end
        digs = $sformatf("%0d", len);
        for (int k = 0; k < digs.len(); k++) begin
            traffic.push_back(digs[k]);
            if ($urandom_range(0, 9) == 0) begin
                do begin
                    junk = ByteWidth'($urandom_range(0, 255));
                end while ((junk >= CHR_ZERO && junk <= CHR_NINE) || junk == CHR_COLON);
                traffic.push_back(junk);
            end
        end
        traffic.push_back(CHR_COLON);
        repeat (len) traffic.push_back(ByteWidth'($urandom_range(0, 255)));
        if (len == 0) begin
            traffic.push_back(ByteWidth'($urandom_range(0, 255)));
        end
    endfunction

    // Mostly frames, the rest broken headers, noise, and oversized lengths that saturate
    // and then run into the limit.
    function automatic void build_traffic(int lim, int target);
        int    pick;
        string hdr;
        hdr = "+IPD,";
        while (traffic.size() < target) begin
            pick = $urandom_range(0, 29);
            if (pick <= 17) begin
                add_frame(lim);
            end else if (pick == 18 && lim <= 300) begin
                push_str(hdr);
                traffic.push_back(ByteWidth'($urandom_range(CHR_ZERO + 1, CHR_NINE)));
                repeat ($urandom_range(5, 7)) begin
                    traffic.push_back(ByteWidth'($urandom_range(CHR_ZERO, CHR_NINE)));
                end
                traffic.push_back(CHR_COLON);
                repeat (lim) traffic.push_back(ByteWidth'($urandom_range(0, 255)));
            end else if (pick <= 23) begin
                push_str(hdr.substr(0, $urandom_range(0, 3)));
                traffic.push_back(ByteWidth'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) traffic.push_back(ByteWidth'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Offer one byte after its idle gap and hold it until the parser takes it.
    task automatic send_byte(input logic [ByteWidth-1:0] value);
        int gap;
        bit hit;
        gap = in_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        do begin
            @(negedge i_clk);
            hit = o_ready;
            @(posedge i_clk);
        end while (!hit);
        parser_ref.take_byte(value);
    endtask

    task automatic send_all();
        while (traffic.size() > 0) begin
            send_byte(traffic.pop_front());
        end
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (parser_ref.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        bit hit;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            hit = pready;
            @(posedge i_clk);
        end while (!hit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        bit hit;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            hit  = pready;
            data = prdata;
            @(posedge i_clk);
        end while (!hit);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_limit(input logic [LimitWidth-1:0] want);
        logic [31:0] rd;
        apb_read(ADDR_FRAME_LIMIT, rd);
        if (rd[LimitWidth-1:0] !== want) begin
            $display("%0t: frame_limit readback expected %0h got %0h", $time, want,
                     rd[LimitWidth-1:0]);
            parser_ref.errors++;
        end
    endtask

    // Drain the parser, let the pipeline settle, then reprogram and read back the limit.
    task automatic change_limit(input logic [LimitWidth-1:0] value);
        wait_drained();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        apb_write(ADDR_FRAME_LIMIT, {{(32 - LimitWidth){1'b0}}, value});
        parser_ref.lim = value;
        @(posedge i_clk);
        verify_limit(value);
    endtask

    // Result side: draw a stall per transaction, or serve a long hold-off when asked.
    initial begin : result_sink
        int      gap;
        bit      hit;
        t_result got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                gap         = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                gap = out_gap();
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                hit             = o_valid;
                got.data_valid  = o_data_valid;
                got.data_byte   = o_data_byte;
                got.frame_done  = o_frame_done;
                got.payload_len = o_payload_len;
                got.frame_abort = o_frame_abort;
                @(posedge i_clk);
            end while (!hit);
            parser_ref.match_result(got);
        end
    end

    // Hang detector: count cycles in which no port moves a transaction.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        parser_ref = new();
        rx_hold_req = 0;
        in_burst    = 1'b0;
        out_burst   = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        verify_limit(LIMIT_RESET);

        // Directed: byte extremes as payload, a broken header whose '+' is not retried,
        // and a zero-length frame whose first length character is ':'.
        push_str("+IPD,2:");
        traffic.push_back(8'h00);
        traffic.push_back(8'hFF);
        push_str("+I+IPD,");
        push_str("+IPD,:0:Q");
        send_all();

        // Reset limit. Hold the result side off for a long stretch while bytes keep
        // coming back to back, so the pipeline fills and stalls the input.
        in_burst    = 1'b1;
        rx_hold_req = 150;
        build_traffic(LIMIT_RESET, 120);
        send_all();
        // pause the byte stream until every result is back
        wait_drained();
        in_burst = 1'b0;
        build_traffic(LIMIT_RESET, 100);
        send_all();

        // lowest limit the bench uses
        change_limit(10'd16);
        build_traffic(16, 150);
        send_all();

        // highest limit: one saturated length that runs past position 1023, then traffic
        change_limit(10'd1023);
        push_str("+IPD,123456:");
        repeat (1020) traffic.push_back(ByteWidth'($urandom_range(0, 255)));
        build_traffic(1023, traffic.size() + 100);
        send_all();

        begin : random_limits
            int lim;
            lim = $urandom_range(17, 300);
            change_limit(LimitWidth'(lim));
            build_traffic(lim, 100);
            send_all();
            lim = $urandom_range(16, 1023);
            change_limit(LimitWidth'(lim));
            build_traffic(lim, 100);
            send_all();
        end

        wait_drained();
        repeat (PIPE_SETTLE * 2) @(posedge i_clk);
        if (parser_ref.errors == 0 && parser_ref.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/ipd_pkg.sv
src/ipd_step.sv
src/ipd_frame_parser.sv
dv/tb.sv
